>>> hw/rtl/wfs_pkg.sv
// Shared types and constants for the wall-follow steering PD core.
// No dependencies; imported by wfs_cfg_regs and wall_follow_steering_pd_core.
`default_nettype none

package wfs_pkg;

  // Fixed tuning constants
  localparam int STEER_LIMIT   = 50;
  localparam int HEADING_LIMIT = 30;
  localparam int SLOW_DISTANCE = 60;
  localparam int MIN_DRIVE     = 20;
  localparam int NO_READING    = 255;
  localparam int DRIVE_MAX     = 150;
  localparam int TOTAL_MARGIN  = 10;
  localparam int TOTAL_LIMIT   = STEER_LIMIT + TOTAL_MARGIN;

  // Reciprocal for cruise*front/SLOW_DISTANCE; exact for products below
  // 2^20/44, and the product never exceeds 255*59.
  localparam int RECIP_SHIFT = 20;
  localparam int SLOW_RECIP  = ((1 << RECIP_SHIFT) + SLOW_DISTANCE - 1) / SLOW_DISTANCE;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_P_GAIN    = 3'd0,
    REG_WALL_D_GAIN    = 3'd1,
    REG_HEADING_P_GAIN = 3'd2,
    REG_HEADING_D_GAIN = 3'd3,
    REG_CRUISE_SPEED   = 3'd4,
    REG_WALL_VALID_LIM = 3'd5,
    REG_WALL_TARGET    = 3'd6,
    REG_WALL_TOO_CLOSE = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [11:0] wall_p_gain;
    logic signed [11:0] wall_d_gain;
    logic signed [11:0] heading_p_gain;
    logic signed [11:0] heading_d_gain;
    logic        [7:0]  cruise_speed;
    logic        [7:0]  wall_valid_limit;
    logic        [7:0]  wall_target;
    logic        [7:0]  wall_too_close;
  } wfs_cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/wfs_cfg_regs.sv
// Configuration register bank for the wall-follow steering core.
// Depends on wfs_pkg (register codes, wfs_cfg_t).
`default_nettype none

module wfs_cfg_regs
  import wfs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output wfs_cfg_t                   cfg_o
);

  wfs_cfg_t cfg_q;
  cfg_reg_e idx;

  assign idx   = cfg_reg_e'(cfg_idx_i);
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wall_p_gain      <= 12'sd256;
      cfg_q.wall_d_gain      <= 12'sd128;
      cfg_q.heading_p_gain   <= 12'sd256;
      cfg_q.heading_d_gain   <= 12'sd64;
      cfg_q.cruise_speed     <= 8'd100;
      cfg_q.wall_valid_limit <= 8'd180;
      cfg_q.wall_target      <= 8'd90;
      cfg_q.wall_too_close   <= 8'd40;
    end else if (cfg_we_i) begin
      unique case (idx)
        REG_WALL_P_GAIN:    cfg_q.wall_p_gain      <= cfg_data_i;
        REG_WALL_D_GAIN:    cfg_q.wall_d_gain      <= cfg_data_i;
        REG_HEADING_P_GAIN: cfg_q.heading_p_gain   <= cfg_data_i;
        REG_HEADING_D_GAIN: cfg_q.heading_d_gain   <= cfg_data_i;
        REG_CRUISE_SPEED:   cfg_q.cruise_speed     <= cfg_data_i[7:0];
        REG_WALL_VALID_LIM: cfg_q.wall_valid_limit <= cfg_data_i[7:0];
        REG_WALL_TARGET:    cfg_q.wall_target      <= cfg_data_i[7:0];
        REG_WALL_TOO_CLOSE: cfg_q.wall_too_close   <= cfg_data_i[7:0];
        default:            cfg_q                  <= cfg_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/wall_follow_steering_pd_core.sv
// Wall-follow steering PD core: top level, pipeline and datapath.
// Depends on wfs_pkg and wfs_cfg_regs.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sensor word: left,
//   right and front range plus heading error. Output channel (out_valid_o /
//   out_stall_i) carries one result word: left and right wheel drive and the
//   clamped steering total. A word moves at an edge where valid is high and
//   stall is low.
//   Pipeline: input register -> product register -> result register; a word
//   passes through each in turn. Throughput is one word per cycle while the
//   receiver does not stall; the only feedback is the previous wall and
//   heading error, which are updated as a word leaves the input register,
//   so no bubble is needed between words.
//   Receiver stall: a stalled result holds; upstream stages keep filling until
//   every stage is full, then in_stall_o rises. in_stall_o is a combinational
//   function of out_stall_i and the stage valid bits.
//   Reset: all stages empty, previous errors zero, registers at their defaults.
//   Configuration: write port (cfg_we_i, cfg_idx_i, cfg_data_i), one register
//   per edge, meant to be written while the pipeline is empty.
`default_nettype none

module wall_follow_steering_pd_core
  import wfs_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [7:0]            left_range_i,
  input  wire logic [7:0]            right_range_i,
  input  wire logic [7:0]            front_range_i,
  input  wire logic signed [12:0]    heading_err_i,
  // result words
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [7:0]            left_drive_o,
  output      logic [7:0]            right_drive_o,
  output      logic signed [8:0]     steer_total_o
);

  wfs_cfg_t cfg;

  wfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // ---------------------------------------------------------------------
  // Handshake: each stage advances when the one after it is free.
  // ---------------------------------------------------------------------
  logic s0_v_q, s1_v_q, out_v_q;
  logic out_free, s1_free, s0_free;
  logic s0_move, s1_move;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s1_free    = !s1_v_q || out_free;
  assign s0_free    = !s0_v_q || s1_free;
  assign in_stall_o = !s0_free;
  assign s0_move    = s0_v_q && s1_free;
  assign s1_move    = s1_v_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_free)  s0_v_q  <= in_valid_i;
      if (s1_free)  s1_v_q  <= s0_move;
      if (out_free) out_v_q <= s1_move;
    end
  end

  assign out_valid_o = out_v_q;

  // ---------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------
  logic [7:0]         left_q, right_q, front_q;
  logic signed [12:0] head_q;

  always_ff @(posedge clk_i) begin
    if (s0_free && in_valid_i) begin
      left_q  <= left_range_i;
      right_q <= right_range_i;
      front_q <= front_range_i;
      head_q  <= heading_err_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0 logic: wall validity, errors, derivatives, products
  // ---------------------------------------------------------------------
  logic signed [8:0]  prev_wall_q, prev_wall_d;
  logic signed [12:0] prev_head_q;

  logic               lv, rv, too_close;
  logic signed [8:0]  diff_lr, err_left, err_right;
  logic signed [9:0]  wall_der;
  logic signed [8:0]  wall_p_arg;
  logic signed [9:0]  wall_d_arg;
  logic signed [20:0] wall_p_prod;
  logic signed [21:0] wall_d_prod;
  logic signed [22:0] wall_sum_d;
  logic signed [13:0] head_der;
  logic signed [24:0] head_p_prod;
  logic signed [25:0] head_d_prod;
  logic signed [26:0] head_sum_d;
  logic               slow_d;
  logic [13:0]        cf_prod_d;

  assign lv = (left_q  != 8'(NO_READING)) && (left_q  < cfg.wall_valid_limit);
  assign rv = (right_q != 8'(NO_READING)) && (right_q < cfg.wall_valid_limit);
  assign too_close = (lv && (left_q  < cfg.wall_too_close)) ||
                     (rv && (right_q < cfg.wall_too_close));

  assign diff_lr   = $signed({1'b0, left_q}) - $signed({1'b0, right_q});
  assign err_left  = $signed({1'b0, left_q}) - $signed({1'b0, cfg.wall_target});
  assign err_right = $signed({1'b0, cfg.wall_target}) - $signed({1'b0, right_q});
  assign wall_der  = 10'(diff_lr) - 10'(prev_wall_q);

  // Operands and the stored error per wall case; no wall gives zero.
  always_comb begin
    if (lv && rv) begin
      wall_p_arg  = diff_lr;
      wall_d_arg  = wall_der;
      prev_wall_d = diff_lr;
    end else if (lv) begin
      wall_p_arg  = err_left;
      wall_d_arg  = '0;
      prev_wall_d = err_left;
    end else if (rv) begin
      wall_p_arg  = err_right;
      wall_d_arg  = '0;
      prev_wall_d = -err_right;
    end else begin
      wall_p_arg  = '0;
      wall_d_arg  = '0;
      prev_wall_d = '0;
    end
  end

  assign wall_p_prod = 21'(cfg.wall_p_gain) * 21'(wall_p_arg);
  assign wall_d_prod = 22'(cfg.wall_d_gain) * 22'(wall_d_arg);
  assign wall_sum_d  = 23'(wall_p_prod) + 23'(wall_d_prod);

  assign head_der    = 14'(head_q) - 14'(prev_head_q);
  assign head_p_prod = 25'(cfg.heading_p_gain) * 25'(head_q);
  assign head_d_prod = 26'(cfg.heading_d_gain) * 26'(head_der);
  assign head_sum_d  = 27'(head_p_prod) + 27'(head_d_prod);

  // front < SLOW_DISTANCE already excludes the no-reading code
  assign slow_d    = front_q < 8'(SLOW_DISTANCE);
  assign cf_prod_d = 14'(cfg.cruise_speed) * 14'(front_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_wall_q <= '0;
      prev_head_q <= '0;
    end else if (s0_move) begin
      prev_wall_q <= prev_wall_d;
      prev_head_q <= head_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: product register
  // ---------------------------------------------------------------------
  logic signed [22:0] wall_sum_q;
  logic signed [26:0] head_sum_q;
  logic               close_q, slow_q;
  logic [13:0]        cf_prod_q;

  always_ff @(posedge clk_i) begin
    if (s0_move) begin
      wall_sum_q <= wall_sum_d;
      head_sum_q <= head_sum_d;
      close_q    <= too_close;
      slow_q     <= slow_d;
      cf_prod_q  <= cf_prod_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1 logic: scaling, clamps, wheel mix
  // ---------------------------------------------------------------------
  logic signed [22:0] wall_adj;
  logic signed [14:0] wall_div;
  logic signed [15:0] wall_dbl;
  logic signed [7:0]  wall_term;
  logic signed [26:0] head_adj;
  logic signed [14:0] head_div;
  logic signed [15:0] head_neg;
  logic signed [7:0]  head_term;
  logic signed [8:0]  total_raw;
  logic signed [7:0]  total;
  logic [28:0]        recip_prod;
  logic [7:0]         slow_base;
  logic [7:0]         base;
  logic signed [10:0] ls_raw, rs_raw, ls_flr, rs_flr;
  logic [7:0]         left_drive_d, right_drive_d;

  // divide by 256 truncating toward zero
  assign wall_adj = wall_sum_q + (wall_sum_q[22] ? 23'sd255 : 23'sd0);
  assign wall_div = wall_adj[22:8];
  assign wall_dbl = close_q ? $signed({wall_div, 1'b0}) : 16'(wall_div);

  always_comb begin
    if (wall_dbl > STEER_LIMIT)       wall_term = 8'(STEER_LIMIT);
    else if (wall_dbl < -STEER_LIMIT) wall_term = 8'(-STEER_LIMIT);
    else                              wall_term = 8'(wall_dbl);
  end

  // divide by 4096 truncating toward zero, then negate
  assign head_adj = head_sum_q + (head_sum_q[26] ? 27'sd4095 : 27'sd0);
  assign head_div = head_adj[26:12];
  assign head_neg = -16'(head_div);

  always_comb begin
    if (head_neg > HEADING_LIMIT)       head_term = 8'(HEADING_LIMIT);
    else if (head_neg < -HEADING_LIMIT) head_term = 8'(-HEADING_LIMIT);
    else                                head_term = 8'(head_neg);
  end

  assign total_raw = 9'(wall_term) + 9'(head_term);

  always_comb begin
    if (total_raw > TOTAL_LIMIT)       total = 8'(TOTAL_LIMIT);
    else if (total_raw < -TOTAL_LIMIT) total = 8'(-TOTAL_LIMIT);
    else                               total = 8'(total_raw);
  end

  // front slow-down: cruise*front/SLOW_DISTANCE by reciprocal
  assign recip_prod = 29'(cf_prod_q) * 29'(SLOW_RECIP);
  assign slow_base  = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];

  always_comb begin
    if (!slow_q)                          base = cfg.cruise_speed;
    else if (slow_base < 8'(MIN_DRIVE))   base = 8'(MIN_DRIVE);
    else if (slow_base > cfg.cruise_speed) base = cfg.cruise_speed;
    else                                  base = slow_base;
  end

  assign ls_raw = $signed({3'b000, base}) - 11'(total);
  assign rs_raw = $signed({3'b000, base}) + 11'(total);

  // minimum-speed floor for small positive values
  assign ls_flr = (ls_raw > 0 && ls_raw < MIN_DRIVE) ? 11'(MIN_DRIVE) : ls_raw;
  assign rs_flr = (rs_raw > 0 && rs_raw < MIN_DRIVE) ? 11'(MIN_DRIVE) : rs_raw;

  always_comb begin
    if (ls_flr < 0)              left_drive_d = '0;
    else if (ls_flr > DRIVE_MAX) left_drive_d = 8'(DRIVE_MAX);
    else                         left_drive_d = ls_flr[7:0];
    if (rs_flr < 0)              right_drive_d = '0;
    else if (rs_flr > DRIVE_MAX) right_drive_d = 8'(DRIVE_MAX);
    else                         right_drive_d = rs_flr[7:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2: result register
  // ---------------------------------------------------------------------
  logic [7:0]        left_drive_q, right_drive_q;
  logic signed [8:0] steer_total_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      left_drive_q  <= left_drive_d;
      right_drive_q <= right_drive_d;
      steer_total_q <= 9'(total);
    end
  end

  assign left_drive_o  = left_drive_q;
  assign right_drive_o = right_drive_q;
  assign steer_total_o = steer_total_q;

endmodule

`default_nettype wire

>>> test/wfs_drive_checker.sv
// Scoreboard for the wall-follow steering PD core: watches the config port and
// both word channels, predicts each drive word and compares it on arrival.
// Depends on wfs_pkg for the limits, the register indexes and the config struct.
module wfs_drive_checker
  import wfs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            left_range_i,
  input  logic [7:0]            right_range_i,
  input  logic [7:0]            front_range_i,
  input  logic signed [12:0]    heading_err_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            left_drive_i,
  input  logic [7:0]            right_drive_i,
  input  logic signed [8:0]     steer_total_i,
  output int                    outstanding_o,
  output int                    errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]        left_drive;
    logic [7:0]        right_drive;
    logic signed [8:0] steer_total;
  } drive_word_t;

  localparam wfs_cfg_t CFG_AT_RESET = '{
    wall_p_gain: 12'sd256, wall_d_gain: 12'sd128,
    heading_p_gain: 12'sd256, heading_d_gain: 12'sd64,
    cruise_speed: 8'd100, wall_valid_limit: 8'd180,
    wall_target: 8'd90, wall_too_close: 8'd40
  };

  wfs_cfg_t           tuning;
  logic signed [8:0]  prev_wall_err;
  logic signed [12:0] prev_head_err;
  drive_word_t        drive_expect_q[$];
  drive_word_t        got, want;
  int                 mismatches;

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the error history and returns the drive word for one sample.
  function automatic drive_word_t predict_drive(input logic [7:0] l8, r8, f8,
                                                input logic signed [12:0] h13);
    int l, r, f, h, lim, tgt, near, cruise, wp, wd, hp, hd;
    int diff, rate, wall, head, total, base, ls, rs;
    bit lv, rv;
    drive_word_t w;
    l = l8; r = r8; f = f8; h = h13;
    lim = tuning.wall_valid_limit;
    tgt = tuning.wall_target;
    near = tuning.wall_too_close;
    cruise = tuning.cruise_speed;
    wp = tuning.wall_p_gain;
    wd = tuning.wall_d_gain;
    hp = tuning.heading_p_gain;
    hd = tuning.heading_d_gain;
    lv = (l != NO_READING) && (l < lim);
    rv = (r != NO_READING) && (r < lim);
    wall = 0;
    if (lv && rv) begin
      diff = l - r;
      rate = diff - prev_wall_err;
      prev_wall_err = 9'(diff);
      wall = (wp * diff + wd * rate) / 256;
    end else if (lv) begin
      diff = l - tgt;
      prev_wall_err = 9'(diff);
      wall = (wp * diff) / 256;
    end else if (rv) begin
      diff = tgt - r;
      prev_wall_err = 9'(-diff);
      wall = (wp * diff) / 256;
    end else begin
      prev_wall_err = '0;
    end
    if ((lv && l < near) || (rv && r < near)) wall = wall * 2;
    wall = clip(wall, -STEER_LIMIT, STEER_LIMIT);

    rate = h - prev_head_err;
    prev_head_err = h13;
    head = clip(-((hp * h + hd * rate) / 4096), -HEADING_LIMIT, HEADING_LIMIT);
    total = clip(wall + head, -TOTAL_LIMIT, TOTAL_LIMIT);

    base = cruise;
    if (f < SLOW_DISTANCE && f != NO_READING) begin
      base = base * f / SLOW_DISTANCE;
      if (base < MIN_DRIVE) base = MIN_DRIVE;
      else if (base > cruise) base = cruise;
    end
    ls = base - total;
    rs = base + total;
    if (ls > 0 && ls < MIN_DRIVE) ls = MIN_DRIVE;
    if (rs > 0 && rs < MIN_DRIVE) rs = MIN_DRIVE;
    w.left_drive  = 8'(clip(ls, 0, DRIVE_MAX));
    w.right_drive = 8'(clip(rs, 0, DRIVE_MAX));
    w.steer_total = 9'(total);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tuning = CFG_AT_RESET;
      prev_wall_err = '0;
      prev_head_err = '0;
      drive_expect_q.delete();
      mismatches = 0;
      outstanding_o <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WALL_P_GAIN:    tuning.wall_p_gain = cfg_data_i;
          REG_WALL_D_GAIN:    tuning.wall_d_gain = cfg_data_i;
          REG_HEADING_P_GAIN: tuning.heading_p_gain = cfg_data_i;
          REG_HEADING_D_GAIN: tuning.heading_d_gain = cfg_data_i;
          REG_CRUISE_SPEED:   tuning.cruise_speed = cfg_data_i[7:0];
          REG_WALL_VALID_LIM: tuning.wall_valid_limit = cfg_data_i[7:0];
          REG_WALL_TARGET:    tuning.wall_target = cfg_data_i[7:0];
          REG_WALL_TOO_CLOSE: tuning.wall_too_close = cfg_data_i[7:0];
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{left_drive_i, right_drive_i, steer_total_i};
        if (drive_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: drive word with none pending: L%0d R%0d S%0d", $realtime,
                     got.left_drive, got.right_drive, got.steer_total);
        end else begin
          want = drive_expect_q.pop_front();
          if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
              got.steer_total !== want.steer_total) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: drive mismatch: want L%0d R%0d S%0d, got L%0d R%0d S%0d",
                       $realtime, want.left_drive, want.right_drive, want.steer_total,
                       got.left_drive, got.right_drive, got.steer_total);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        drive_expect_q.push_back(predict_drive(left_range_i, right_range_i,
                                               front_range_i, heading_err_i));
      outstanding_o <= drive_expect_q.size();
      errors_o <= mismatches;
    end
  end

endmodule

>>> test/wall_follow_steering_pd_core_test.sv
// Top of the wall-follow steering PD core regression: clock, reset, sensor
// stimulus, receiver stalls, watchdog and verdict. Depends on wfs_pkg,
// wall_follow_steering_pd_core and wfs_drive_checker.
module wall_follow_steering_pd_core_test;
  import wfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS_PER_PHASE = 172;   // words in each of the six random phases
  localparam int QUIET_LIMIT     = 2000;  // cycles without any word moving
  localparam int HOLD_CYCLES     = 60;    // long receiver hold-off

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = REG_WALL_P_GAIN;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            left_range_i = '0;
  logic [7:0]            right_range_i = '0;
  logic [7:0]            front_range_i = '0;
  logic signed [12:0]    heading_err_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            left_drive_o;
  logic [7:0]            right_drive_o;
  logic signed [8:0]     steer_total_o;

  int drive_outstanding;
  int drive_errors;

  // Idle percentages for each side, a pending hold-off request for the
  // receiver, and the current thresholds so random ranges can land near them.
  int send_gap_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;
  int cur_limit = 180;
  int cur_target = 90;
  int cur_close = 40;
  int last_heading = 0;

  wall_follow_steering_pd_core u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .left_range_i, .right_range_i, .front_range_i, .heading_err_i,
    .out_valid_o, .out_stall_i,
    .left_drive_o, .right_drive_o, .steer_total_o
  );

  wfs_drive_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .left_range_i, .right_range_i, .front_range_i, .heading_err_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .left_drive_i(left_drive_o), .right_drive_i(right_drive_o),
    .steer_total_i(steer_total_o),
    .outstanding_o(drive_outstanding), .errors_o(drive_errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: random stall at stall_pct, or a solid hold-off when asked.
  // During a hold-off the sender keeps offering, so the three pipeline
  // stages fill and in_stall_o must rise.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        hold_len = 0;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any word moving on either channel restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("wall_follow_steering_pd_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One sensor word: optional idle cycles first, then hold valid and the
  // payload steady until the word is taken.
  task automatic send_sample(input int l, input int r, input int f, input int h);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    left_range_i  <= 8'(l);
    right_range_i <= 8'(r);
    front_range_i <= 8'(f);
    heading_err_i <= 13'(h);
    last_heading = h;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits for the pipeline to drain, then rewrites every register. The upper
  // nibble of the byte-wide registers carries junk the core has to drop.
  task automatic load_settings(input int wp, input int wd, input int hp, input int hd,
                               input int cruise, input int vlim, input int tgt,
                               input int close_lim);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_outstanding != 0);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_WALL_P_GAIN;
    cfg_data_i <= 12'(wp);
    @(posedge clk_i);
    cfg_idx_i  <= REG_WALL_D_GAIN;
    cfg_data_i <= 12'(wd);
    @(posedge clk_i);
    cfg_idx_i  <= REG_HEADING_P_GAIN;
    cfg_data_i <= 12'(hp);
    @(posedge clk_i);
    cfg_idx_i  <= REG_HEADING_D_GAIN;
    cfg_data_i <= 12'(hd);
    @(posedge clk_i);
    cfg_idx_i  <= REG_CRUISE_SPEED;
    cfg_data_i <= {4'($urandom_range(0, 15)), 8'(cruise)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_WALL_VALID_LIM;
    cfg_data_i <= {4'($urandom_range(0, 15)), 8'(vlim)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_WALL_TARGET;
    cfg_data_i <= {4'($urandom_range(0, 15)), 8'(tgt)};
    @(posedge clk_i);
    cfg_idx_i  <= REG_WALL_TOO_CLOSE;
    cfg_data_i <= {4'($urandom_range(0, 15)), 8'(close_lim)};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_limit  = vlim;
    cur_target = tgt;
    cur_close  = close_lim;
  endtask

  function automatic int clamp_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // Side range: biased toward the no-reading code and the three thresholds,
  // so wall valid / too close / on target flip often.
  function automatic int pick_side();
    case ($urandom_range(0, 9))
      0:       return NO_READING;
      1:       return clamp_byte(cur_limit - 2 + int'($urandom_range(0, 3)));
      2:       return clamp_byte(cur_close - 2 + int'($urandom_range(0, 3)));
      3:       return clamp_byte(cur_target - 3 + int'($urandom_range(0, 6)));
      default: return int'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_front();
    case ($urandom_range(0, 7))
      0:       return NO_READING;
      1, 2, 3: return int'($urandom_range(0, SLOW_DISTANCE - 1));
      4:       return SLOW_DISTANCE - 1 + int'($urandom_range(0, 2));
      default: return int'($urandom_range(0, 255));
    endcase
  endfunction

  // Heading: mostly a smooth walk (what a real gyro gives), plus small
  // values, full-scale noise and the two extremes.
  function automatic int pick_heading();
    int h;
    case ($urandom_range(0, 9))
      0:       h = $urandom_range(0, 1) ? 4095 : -4096;
      1, 2:    h = int'($urandom_range(0, 8191)) - 4096;
      3, 4:    h = int'($urandom_range(0, 400)) - 200;
      default: h = last_heading + int'($urandom_range(0, 64)) - 32;
    endcase
    if (h < -4096) h = -4096;
    if (h > 4095) h = 4095;
    return h;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset settings (gains 256/128/256/64, cruise 100,
    // wall limit 180, target 90, too close 40).
    send_sample(100, 100, 255, 0);        // both walls, centered
    send_sample(120, 80, 255, 0);         // both walls, PD on difference
    send_sample(60, 255, 255, 0);         // left wall only
    send_sample(255, 60, 255, 0);         // right wall only
    send_sample(255, 255, 255, 0);        // no reading either side
    send_sample(200, 250, 255, 0);        // both beyond the wall limit
    send_sample(179, 180, 255, 0);        // limit edge: left valid, right not
    send_sample(30, 100, 255, 0);         // left too close, term doubled
    send_sample(100, 10, 255, 0);         // right too close
    send_sample(0, 0, 0, 0);              // zero ranges, front at zero
    send_sample(90, 255, 59, 0);          // front just inside slow-down
    send_sample(90, 255, 60, 0);          // front at slow distance, no cut
    send_sample(255, 255, 30, 0);         // half speed
    send_sample(255, 255, 10, 0);         // cut below minimum, floored
    send_sample(255, 255, 10, -64);       // small steer, wheel floor kicks in
    send_sample(255, 255, 255, 4095);     // heading extreme
    send_sample(255, 255, 255, -4096);    // opposite extreme, big derivative
    send_sample(255, 255, 255, 0);
    send_sample(255, 255, 255, 16);
    send_sample(255, 255, 255, -160);
    send_sample(179, 0, 255, -4096);      // wall and heading both saturate
    send_sample(0, 179, 5, 4095);         // saturated the other way, slowed
    send_sample(254, 254, 254, 1);

    // Random phases: idling pattern changes every two phases, settings
    // change every phase, extremes first.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       load_settings(384, -96, 200, 40, 150, 200, 80, 30);
        1:       load_settings(2047, -2048, -2048, 2047, 255, 255, 0, 255);
        2:       load_settings(-2048, 2047, 2047, -2048, 0, 0, 255, 0);
        default: load_settings(int'($urandom_range(0, 1200)) - 600,
                               int'($urandom_range(0, 1200)) - 600,
                               int'($urandom_range(0, 1200)) - 600,
                               int'($urandom_range(0, 1200)) - 600,
                               int'($urandom_range(0, 255)),
                               int'($urandom_range(60, 255)),
                               int'($urandom_range(0, 255)),
                               int'($urandom_range(0, 100)));
      endcase
      if (phase < 2) begin
        send_gap_pct = 10;
        stall_pct = 73;
      end else if (phase < 4) begin
        send_gap_pct = 73;
        stall_pct = 10;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      if (phase == 0 || phase == 4) hold_len = HOLD_CYCLES;
      repeat (WORDS_PER_PHASE)
        send_sample(pick_side(), pick_side(), pick_front(), pick_heading());
    end

    // Drain, then give the pipeline a few more cycles to show any stray word.
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (drive_outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (drive_errors == 0)
      $display("wall_follow_steering_pd_core regression: pass");
    else
      $display("wall_follow_steering_pd_core regression: fail");
    $finish;
  end

endmodule
